>>> rtl/core/llpm_pkg.sv
// Shared types and constants for the linked list pool manager.
package llpm_pkg;

    localparam int NUM_ENTRIES = 1024;
    localparam int NUM_LISTS   = 8;

    typedef enum logic [2:0] {
        OP_MOVE        = 3'd0,
        OP_ALLOC_MISC  = 3'd1,
        OP_ALLOC_MONEY = 3'd2,
        OP_ALLOC_VEH   = 3'd3,
        OP_FREE        = 3'd4,
        OP_QUERY       = 3'd5
    } op_t;

    localparam logic [2:0] LIST_FREE       = 3'd0;
    localparam logic [2:0] LIST_FREE_MONEY = 3'd1;
    localparam logic [2:0] LIST_VEHICLE    = 3'd2;
    localparam logic [2:0] LIST_MISC       = 3'd3;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_FETCH_PREV,
        ST_UNLINK_PREV,
        ST_UNLINK_NEXT,
        ST_LINK_HEAD,
        ST_WRITE_ENTRY,
        ST_OUT
    } state_t;

endpackage

>>> rtl/core/llpm_link_ram.sv
// Entry link memory: next, previous and owner per entry, one read and one write port.
module llpm_link_ram
    import llpm_pkg::*;
#(
    parameter int AW = 10,
    parameter int LW = 11
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [LW-1:0] wnext,
    input  logic [LW-1:0] wprev,
    input  logic [2:0]    wown,
    input  logic [AW-1:0] raddr,
    output logic [LW-1:0] rnext,
    output logic [LW-1:0] rprev,
    output logic [2:0]    rown
);

    logic [2*LW+2:0] mem [0:(1<<AW)-1];
    logic [2*LW+2:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wown, wprev, wnext};
        end
        rdata_reg <= mem[raddr];
    end

    assign rnext = rdata_reg[LW-1:0];
    assign rprev = rdata_reg[2*LW-1:LW];
    assign rown  = rdata_reg[2*LW+2:2*LW];

endmodule

>>> rtl/core/linked_list_pool_manager_core.sv
// Top level of the linked list pool manager: sequencer, list registers and stream ports.
//
// channel   | dir | tdata fields (low first)                      | tuser
// s_axis    | in  | op[2:0] entry[12:3] target[15:13]             | -
// m_axis    | out | ok[0] entry_id[11:1] head[22:12] count[33:23] | -
// cfg       | in  | misc_limit[10:0]                              | -
//
// Every operation passes from acceptance to the next ready through decode, entry read,
// previous-neighbor read, three neighbor read-modify-writes, entry write, output load;
// that load fills the output register and waits while the register is still full.
// After reset a clearing pass over all NUM_ENTRIES entries chains the links; no
// transaction is accepted until it ends.
// Hold the sequencer in its output step while the output register still waits.
module linked_list_pool_manager_core
    import llpm_pkg::*;
#(
    parameter int NORMAL_ENTRIES = 960
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // op, entry, target_list
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // ok, entry_id, head, count
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata
);

    localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int LW = $clog2(NUM_ENTRIES + 1);
    localparam int NLW = $clog2(NUM_LISTS);
    localparam logic [LW-1:0] NIL = LW'(NUM_ENTRIES);
    localparam logic [LW-1:0] SPLIT =
        LW'((NORMAL_ENTRIES > NUM_ENTRIES) ? NUM_ENTRIES : NORMAL_ENTRIES);

    state_t state_reg, state_next;

    logic [LW-1:0] head_reg  [0:NUM_LISTS-1];
    logic [LW-1:0] count_reg [0:NUM_LISTS-1];
    logic [10:0]   misc_limit_reg;

    logic [2:0]  op_reg;
    logic [9:0]  ent_in_reg;
    logic [2:0]  tgt_in_reg;
    logic [LW-1:0] e_reg;
    logic [2:0]  dst_reg;
    logic [LW-1:0] nx_reg, pv_reg, h_reg;
    logic [2:0]  old_reg;
    logic        ok_reg, rep_valid_reg;
    logic [AW-1:0] init_reg;
    logic        out_valid_reg;
    logic [39:0] out_data_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [LW-1:0] wnext, wprev, rnext, rprev;
    logic [2:0]    wown, rown;

    logic          accept;
    logic          load_out;
    logic          alloc_op;
    logic [2:0]    alloc_src;
    logic [LW-1:0] rep_head, rep_count, rep_id;

    function automatic logic lvalid(input logic [2:0] l);
        lvalid = (32'(l) < NUM_LISTS);
    endfunction

    llpm_link_ram #(.AW(AW), .LW(LW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wnext(wnext), .wprev(wprev),
        .wown(wown), .raddr(raddr), .rnext(rnext), .rprev(rprev), .rown(rown)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    assign alloc_op = (op_reg == OP_ALLOC_MISC) || (op_reg == OP_ALLOC_MONEY) ||
                      (op_reg == OP_ALLOC_VEH);
    assign alloc_src = (op_reg == OP_ALLOC_MONEY) ? LIST_FREE_MONEY : LIST_FREE;

    logic [LW-1:0] init_ext;
    assign init_ext = LW'(init_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:        if (32'(init_reg) == NUM_ENTRIES - 1) state_next = ST_IDLE;
            ST_IDLE:        if (accept) state_next = ST_DECODE;
            ST_DECODE:      state_next = ST_READ;
            ST_READ:        state_next = ST_FETCH_PREV;
            ST_FETCH_PREV:  state_next = ST_UNLINK_PREV;
            ST_UNLINK_PREV: state_next = ST_UNLINK_NEXT;
            ST_UNLINK_NEXT: state_next = ST_LINK_HEAD;
            ST_LINK_HEAD:   state_next = ST_WRITE_ENTRY;
            ST_WRITE_ENTRY: state_next = ST_OUT;
            ST_OUT:         if (load_out) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // Memory port control.
    always_comb
    begin
        we = 1'b0;
        waddr = '0;
        wnext = NIL;
        wprev = NIL;
        wown = LIST_FREE;
        raddr = e_reg[AW-1:0];
        unique case (state_reg)
            ST_INIT:
            begin
                we = 1'b1;
                waddr = init_reg;
                wnext = (init_ext + 1'b1 == SPLIT || 32'(init_ext) + 1 == NUM_ENTRIES)
                        ? NIL : init_ext + 1'b1;
                wprev = (init_ext == '0 || init_ext == SPLIT) ? NIL : init_ext - 1'b1;
                wown = (init_ext < SPLIT) ? LIST_FREE : LIST_FREE_MONEY;
            end
            ST_FETCH_PREV:
            begin
                raddr = rprev[AW-1:0];
            end
            ST_UNLINK_PREV:
            begin
                raddr = nx_reg[AW-1:0];
                we = rep_valid_reg && pv_reg < NIL;
                waddr = pv_reg[AW-1:0];
                wnext = nx_reg;
                wprev = rprev;
                wown = rown;
            end
            ST_UNLINK_NEXT:
            begin
                raddr = h_reg[AW-1:0];
                we = rep_valid_reg && nx_reg < NIL;
                waddr = nx_reg[AW-1:0];
                wnext = rnext;
                wprev = pv_reg;
                wown = rown;
            end
            ST_LINK_HEAD:
            begin
                we = rep_valid_reg && h_reg < NIL;
                waddr = h_reg[AW-1:0];
                wnext = rnext;
                wprev = e_reg;
                wown = rown;
            end
            ST_WRITE_ENTRY:
            begin
                we = rep_valid_reg;
                waddr = e_reg[AW-1:0];
                wnext = h_reg;
                wprev = NIL;
                wown = dst_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        rep_head = lvalid(dst_reg) ? head_reg[dst_reg[NLW-1:0]] : NIL;
        rep_count = lvalid(dst_reg) ? count_reg[dst_reg[NLW-1:0]] : '0;
        if (!ok_reg && !alloc_op)
        begin
            rep_head = NIL;
            rep_count = '0;
        end
        rep_id = (ok_reg && op_reg != OP_QUERY) ? e_reg : NIL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            init_reg <= '0;
            misc_limit_reg <= 11'd1024;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                if (i == int'(LIST_FREE))
                begin
                    head_reg[i] <= (SPLIT > 0) ? '0 : NIL;
                    count_reg[i] <= SPLIT;
                end
                else if (i == int'(LIST_FREE_MONEY))
                begin
                    head_reg[i] <= (SPLIT < NIL) ? SPLIT : NIL;
                    count_reg[i] <= NIL - SPLIT;
                end
                else
                begin
                    head_reg[i] <= NIL;
                    count_reg[i] <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we) misc_limit_reg <= cfg_wdata;
            if (state_reg == ST_INIT) init_reg <= init_reg + 1'b1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_UNLINK_PREV && rep_valid_reg && pv_reg >= NIL &&
                lvalid(old_reg))
                head_reg[old_reg[NLW-1:0]] <= nx_reg;
            if (state_reg == ST_WRITE_ENTRY && rep_valid_reg)
            begin
                head_reg[dst_reg[NLW-1:0]] <= e_reg;
                if (lvalid(old_reg) && count_reg[old_reg[NLW-1:0]] != '0)
                    count_reg[old_reg[NLW-1:0]] <= count_reg[old_reg[NLW-1:0]] - 1'b1;
                count_reg[dst_reg[NLW-1:0]] <= count_reg[dst_reg[NLW-1:0]] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= s_axis_tdata[2:0];
            ent_in_reg <= s_axis_tdata[12:3];
            tgt_in_reg <= s_axis_tdata[15:13];
        end
        if (state_reg == ST_DECODE)
        begin
            if (alloc_op)
            begin
                e_reg <= head_reg[alloc_src];
                dst_reg <= (op_reg == OP_ALLOC_VEH) ? LIST_VEHICLE : LIST_MISC;
                ok_reg <= !((op_reg == OP_ALLOC_MISC &&
                             11'(count_reg[LIST_MISC]) >= misc_limit_reg) ||
                            count_reg[alloc_src] == '0 || head_reg[alloc_src] >= NIL);
            end
            else if (op_reg == OP_MOVE)
            begin
                e_reg <= LW'(ent_in_reg);
                dst_reg <= tgt_in_reg;
                ok_reg <= (32'(ent_in_reg) < NUM_ENTRIES) && lvalid(tgt_in_reg);
            end
            else if (op_reg == OP_FREE)
            begin
                e_reg <= LW'(ent_in_reg);
                dst_reg <= (32'(ent_in_reg) < NORMAL_ENTRIES) ? LIST_FREE : LIST_FREE_MONEY;
                ok_reg <= (32'(ent_in_reg) < NUM_ENTRIES);
            end
            else
            begin
                e_reg <= '0;
                dst_reg <= tgt_in_reg;
                ok_reg <= (op_reg == OP_QUERY) && lvalid(tgt_in_reg);
            end
        end
        if (state_reg == ST_FETCH_PREV)
        begin
            nx_reg <= rnext;
            pv_reg <= rprev;
            old_reg <= rown;
            h_reg <= head_reg[dst_reg[NLW-1:0]];
            rep_valid_reg <= ok_reg && op_reg != OP_QUERY && rown != dst_reg;
        end
        if (load_out)
            out_data_reg <= {6'd0, 11'(rep_count), 11'(rep_head), 11'(rep_id), ok_reg};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_init_noacc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INIT |-> !s_axis_tready) else $error("accept during init");
    a_out_follow: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_DECODE) else $error("sequencer skipped decode");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while waiting");

endmodule

>>> tb/sv/linked_list_pool_manager_core_chk.sv
// Checker for the linked list pool manager: list-state predictor and result comparison.
`timescale 1ns / 100ps
module linked_list_pool_manager_core_chk
    import llpm_pkg::*;
#(
    parameter int NORMAL_ENTRIES = 960
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);

    localparam logic [10:0] NIL = 11'(NUM_ENTRIES);

    typedef struct packed {
        logic [10:0] count;
        logic [10:0] head;
        logic [10:0] entry_id;
        logic        ok;
    } result_t;

    logic [10:0] nxt [NUM_ENTRIES];
    logic [10:0] prv [NUM_ENTRIES];
    logic [2:0]  owner [NUM_ENTRIES];
    logic [10:0] head_of [NUM_LISTS];
    logic [10:0] count_of [NUM_LISTS];
    logic [10:0] misc_cap;
    result_t     expected_q [$];

    function automatic void pool_init();
        for (int l = 0; l < NUM_LISTS; l++)
        begin
            head_of[l] = NIL;
            count_of[l] = '0;
        end
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            owner[i] = (i < NORMAL_ENTRIES) ? LIST_FREE : LIST_FREE_MONEY;
            prv[i] = (i == 0 || i == NORMAL_ENTRIES) ? NIL : 11'(i - 1);
            nxt[i] = (i + 1 == NORMAL_ENTRIES || i + 1 == NUM_ENTRIES) ? NIL : 11'(i + 1);
        end
        head_of[LIST_FREE] = '0;
        head_of[LIST_FREE_MONEY] = 11'(NORMAL_ENTRIES);
        count_of[LIST_FREE] = 11'(NORMAL_ENTRIES);
        count_of[LIST_FREE_MONEY] = 11'(NUM_ENTRIES - NORMAL_ENTRIES);
        misc_cap = 11'd1024;
    endfunction

    function automatic void relink(int e, int l);
        int old, nx, pv, h;
        old = owner[e];
        if (old == l)
            return;
        nx = nxt[e];
        pv = prv[e];
        if (pv >= NUM_ENTRIES)
            head_of[old] = 11'(nx);
        else
            nxt[pv] = 11'(nx);
        if (nx < NUM_ENTRIES)
            prv[nx] = 11'(pv);
        h = head_of[l];
        prv[e] = NIL;
        owner[e] = 3'(l);
        nxt[e] = 11'(h);
        head_of[l] = 11'(e);
        if (h < NUM_ENTRIES)
            prv[h] = 11'(e);
        if (count_of[old] > 0)
            count_of[old]--;
        count_of[l]++;
    endfunction

    function automatic result_t report(logic ok, logic [10:0] id, int l);
        result_t r;
        r.ok = ok;
        r.entry_id = id;
        r.head = (l < NUM_LISTS) ? head_of[l] : NIL;
        r.count = (l < NUM_LISTS) ? count_of[l] : '0;
        return r;
    endfunction

    function automatic result_t take_from(int src, int dst, bit capped);
        int id;
        if ((capped && count_of[LIST_MISC] >= misc_cap) || count_of[src] == 0)
            return report(1'b0, NIL, dst);
        id = head_of[src];
        if (id >= NUM_ENTRIES)
            return report(1'b0, NIL, dst);
        relink(id, dst);
        return report(1'b1, 11'(id), dst);
    endfunction

    function automatic result_t pool_step(logic [2:0] op, logic [9:0] e, logic [2:0] l);
        int fl;
        case (op)
            OP_MOVE:
            begin
                if (l >= NUM_LISTS)
                    return report(1'b0, NIL, NUM_LISTS);
                relink(e, l);
                return report(1'b1, 11'(e), l);
            end
            OP_ALLOC_MISC:  return take_from(LIST_FREE, LIST_MISC, 1'b1);
            OP_ALLOC_MONEY: return take_from(LIST_FREE_MONEY, LIST_MISC, 1'b0);
            OP_ALLOC_VEH:   return take_from(LIST_FREE, LIST_VEHICLE, 1'b0);
            OP_FREE:
            begin
                fl = (e < NORMAL_ENTRIES) ? LIST_FREE : LIST_FREE_MONEY;
                relink(e, fl);
                return report(1'b1, 11'(e), fl);
            end
            OP_QUERY:
            begin
                if (l >= NUM_LISTS)
                    return report(1'b0, NIL, NUM_LISTS);
                return report(1'b1, NIL, l);
            end
            default: return report(1'b0, NIL, NUM_LISTS);
        endcase
    endfunction

    initial
    begin
        fail_count = 0;
        results_seen = 0;
        pending = 0;
        pool_init();
    end

    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n)
        begin
            if (cfg_we)
                misc_cap = cfg_wdata;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[33:0];
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch #%0d: exp ok=%0d id=%0d head=%0d cnt=%0d,",
                                      " got ok=%0d id=%0d head=%0d cnt=%0d"},
                                results_seen, want.ok, want.entry_id, want.head, want.count,
                                got.ok, got.entry_id, got.head, got.count);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(pool_step(s_axis_tdata[2:0], s_axis_tdata[12:3],
                    s_axis_tdata[15:13]));
            pending = expected_q.size();
        end
    end

endmodule

>>> tb/sv/linked_list_pool_manager_core_tb.sv
// Testbench top for the linked list pool manager: stimulus, reset, watchdog and verdict.
`timescale 1ns / 100ps
module linked_list_pool_manager_core_tb;
    import llpm_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [10:0] cfg_wdata = '0;
    int          fail_count, pending, results_seen;
    int          idle_cycles = 0;
    bit          calm = 1'b0;
    int          sent = 0;

    always #10 clk = ~clk;

    linked_list_pool_manager_core dut (.*);

    linked_list_pool_manager_core_chk chk (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen));

    always @(posedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(99) >= 34);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("linked_list_pool_manager_core regression: fail");
            $finish;
        end
    end

    task automatic send_op(logic [2:0] op, logic [9:0] e, logic [2:0] l);
        while (!calm && $urandom_range(99) < 34)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {l, e, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent++;
    endtask

    task automatic set_misc_cap(logic [10:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n);
        logic [2:0] op;
        logic [9:0] e;
        for (int i = 0; i < n; i++)
        begin
            calm = (i > n / 3 && i < n / 2);
            case ($urandom_range(9))
                0, 1:    op = OP_MOVE;
                2, 3:    op = OP_ALLOC_MISC;
                4:       op = OP_ALLOC_MONEY;
                5:       op = OP_ALLOC_VEH;
                6, 7:    op = OP_FREE;
                8:       op = OP_QUERY;
                default: op = 3'($urandom_range(7));
            endcase
            e = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(63) +
                ($urandom_range(1) ? 0 : 940));
            send_op(op, e, 3'($urandom));
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (!s_axis_tready)
            @(posedge clk);
        send_op(OP_QUERY, 10'd0, LIST_FREE);
        send_op(OP_QUERY, 10'd0, LIST_FREE_MONEY);
        send_op(OP_ALLOC_MISC, 10'd0, 3'd0);
        send_op(OP_ALLOC_MONEY, 10'd0, 3'd0);
        send_op(OP_ALLOC_VEH, 10'd0, 3'd0);
        send_op(OP_MOVE, 10'd0, LIST_MISC);
        send_op(OP_MOVE, 10'd0, LIST_MISC);
        send_op(OP_MOVE, 10'd1023, 3'd7);
        send_op(OP_MOVE, 10'd5, 3'd7);
        send_op(OP_FREE, 10'd959, 3'd0);
        send_op(OP_FREE, 10'd960, 3'd0);
        send_op(OP_FREE, 10'd1023, 3'd0);
        send_op(OP_FREE, 10'd0, 3'd0);
        send_op(OP_QUERY, 10'd1023, 3'd7);
        send_op(3'd6, 10'h3ff, 3'd7);
        send_op(3'd7, 10'd0, 3'd0);
        set_misc_cap(11'd0);
        send_op(OP_ALLOC_MISC, 10'd0, 3'd0);
        for (int i = 0; i < 66; i++)
            send_op(OP_ALLOC_MONEY, 10'd0, 3'd0);
        send_op(OP_QUERY, 10'd0, LIST_MISC);
        set_misc_cap(11'd4);
        random_phase(400);
        set_misc_cap(11'h7ff);
        random_phase(300);
        set_misc_cap(11'd1024);
        random_phase(300);
        set_misc_cap(11'd300);
        random_phase(300);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        $display("ran %0d operations over several misc limits, %0d results checked",
            sent, results_seen);
        if (fail_count == 0 && pending == 0)
            $display("linked_list_pool_manager_core regression: pass");
        else
            $display("linked_list_pool_manager_core regression: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/core/llpm_pkg.sv
rtl/core/llpm_link_ram.sv
rtl/core/linked_list_pool_manager_core.sv
tb/sv/linked_list_pool_manager_core_chk.sv
tb/sv/linked_list_pool_manager_core_tb.sv
